/* rtl/stl_pkg.sv */
package stl_pkg;

  // token types carried at the close of a token
  localparam logic [2:0] TT_KEY = 3'd0;
  localparam logic [2:0] TT_ERR = 3'd1;
  localparam logic [2:0] TT_STR = 3'd2;
  localparam logic [2:0] TT_NUM = 3'd3;
  localparam logic [2:0] TT_TAG = 3'd4;

  // error codes
  localparam logic [2:0] EC_NONE      = 3'd0;
  localparam logic [2:0] EC_OPEN_STR  = 3'd1;
  localparam logic [2:0] EC_OPEN_ESC  = 3'd2;
  localparam logic [2:0] EC_EOF_CHAR  = 3'd3;
  localparam logic [2:0] EC_BAD_CHAR  = 3'd4;

  // work handed from the front to the back
  typedef enum logic [2:0] {
    OP_BYTE     = 3'd0,  // one text byte, token still open
    OP_END      = 3'd1,  // close with type (and error code), no text
    OP_KEY      = 3'd2,  // key character token
    OP_WORD_KEY = 3'd3,  // close a word, then a key character token
    OP_LIT      = 3'd4   // character literal, expand to decimal text
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [2:0] tok_type;
    logic [2:0] err;
  } cmd_t;

endpackage

/* rtl/stl_front.sv */
module stl_front import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       in_kind,
  input  logic [7:0] in_char_byte,
  output logic       push,
  output cmd_t       push_cmd
);

  typedef enum logic [8:0] {
    M_IDLE        = 9'b000000001,
    M_WORD        = 9'b000000010,
    M_STR         = 9'b000000100,
    M_STR_ESC     = 9'b000001000,
    M_STR_CUT     = 9'b000010000,
    M_STR_CUT_ESC = 9'b000100000,
    M_CH_OPEN     = 9'b001000000,
    M_CH_ESC      = 9'b010000000,
    M_CH_CLOSE    = 9'b100000000
  } mode_t;

  typedef enum logic [7:0] {
    C_START  = 8'b00000001,
    C_SIGN   = 8'b00000010,
    C_ZERO   = 8'b00000100,
    C_HEXPFX = 8'b00001000,
    C_HEX    = 8'b00010000,
    C_OCT    = 8'b00100000,
    C_DEC    = 8'b01000000,
    C_DEAD   = 8'b10000000
  } class_t;

  function automatic class_t class_next(input class_t s, input logic [7:0] b);
    logic   dig;
    logic   oct;
    logic   hex;
    class_t r;
    dig = (b >= 8'h30) && (b <= 8'h39);
    oct = (b >= 8'h30) && (b <= 8'h37);
    hex = dig || ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
    r = C_DEAD;
    unique case (s)
      C_START, C_SIGN: begin
        if ((s == C_START) && ((b == 8'h2b) || (b == 8'h2d))) r = C_SIGN;
        else if (b == 8'h30) r = C_ZERO;
        else if (dig) r = C_DEC;
        else r = C_DEAD;
      end
      C_ZERO: begin
        if ((b == 8'h78) || (b == 8'h58)) r = C_HEXPFX;
        else if (oct) r = C_OCT;
        else r = C_DEAD;
      end
      C_HEXPFX, C_HEX: r = hex ? C_HEX : C_DEAD;
      C_OCT:           r = oct ? C_OCT : C_DEAD;
      C_DEC:           r = dig ? C_DEC : C_DEAD;
      default:         r = C_DEAD;
    endcase
    return r;
  endfunction

  mode_t      mode_r, mode_nxt;
  class_t     class_r, class_nxt;
  logic [7:0] lit_r, lit_nxt;

  logic       eof;
  logic [7:0] ch;
  logic       is_ws;
  logic       is_key;
  logic       accepts;
  logic [7:0] esc_str;
  logic [7:0] esc_ch;

  assign eof = in_kind;
  assign ch  = in_char_byte;
  assign is_ws = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0d));
  assign is_key = (ch == 8'h00) || (ch == 8'h21) || (ch == 8'h40) || (ch == 8'h23) ||
                  (ch == 8'h28) || (ch == 8'h29) || (ch == 8'h5b) || (ch == 8'h5d);
  assign accepts = (class_r == C_ZERO) || (class_r == C_HEX) ||
                   (class_r == C_OCT) || (class_r == C_DEC);

  always_comb begin
    if (ch == 8'h6e) esc_str = 8'h0a;
    else if (ch == 8'h74) esc_str = 8'h09;
    else if (ch == 8'h5b) esc_str = 8'h1b;
    else esc_str = ch;
  end

  always_comb begin
    if (ch == 8'h6e) esc_ch = 8'h0a;
    else if (ch == 8'h74) esc_ch = 8'h09;
    else if (ch == 8'h62) esc_ch = 8'h08;
    else if (ch == 8'h5b) esc_ch = 8'h1b;
    else esc_ch = ch;
  end

  always_comb begin
    mode_nxt  = mode_r;
    class_nxt = class_r;
    lit_nxt   = lit_r;
    push      = 1'b0;
    push_cmd  = '{op: OP_BYTE, data: ch, tok_type: TT_KEY, err: EC_NONE};
    unique case (mode_r)
      M_WORD: begin
        if (eof || is_ws || is_key) begin
          push = 1'b1;
          push_cmd.tok_type = accepts ? TT_NUM : TT_TAG;
          push_cmd.op = (!eof && is_key) ? OP_WORD_KEY : OP_END;
          mode_nxt = M_IDLE;
        end else begin
          class_nxt = class_next(class_r, ch);
          push = 1'b1;
        end
      end
      M_STR, M_STR_CUT: begin
        if (eof) begin
          push = 1'b1;
          push_cmd.op = OP_END;
          push_cmd.tok_type = TT_ERR;
          push_cmd.err = EC_OPEN_STR;
          mode_nxt = M_IDLE;
        end else if (ch == 8'h5c) begin
          mode_nxt = (mode_r == M_STR) ? M_STR_ESC : M_STR_CUT_ESC;
        end else if (ch == 8'h22) begin
          push = 1'b1;
          push_cmd.op = OP_END;
          push_cmd.tok_type = TT_STR;
          mode_nxt = M_IDLE;
        end else if ((mode_r == M_STR_CUT) || (ch == 8'h00)) begin
          // text ended at a NUL: swallow until the closing quote
          mode_nxt = M_STR_CUT;
        end else begin
          mode_nxt = M_STR;
          push = 1'b1;
        end
      end
      M_STR_ESC, M_STR_CUT_ESC: begin
        if (eof) begin
          push = 1'b1;
          push_cmd.op = OP_END;
          push_cmd.tok_type = TT_ERR;
          push_cmd.err = EC_OPEN_ESC;
          mode_nxt = M_IDLE;
        end else if ((mode_r == M_STR_CUT_ESC) || (esc_str == 8'h00)) begin
          mode_nxt = M_STR_CUT;
        end else begin
          mode_nxt = M_STR;
          push = 1'b1;
          push_cmd.data = esc_str;
        end
      end
      M_CH_OPEN: begin
        if (eof) begin
          push = 1'b1;
          push_cmd.op = OP_END;
          push_cmd.tok_type = TT_ERR;
          push_cmd.err = EC_EOF_CHAR;
          mode_nxt = M_IDLE;
        end else if (ch == 8'h5c) begin
          mode_nxt = M_CH_ESC;
        end else begin
          lit_nxt = ch;
          mode_nxt = M_CH_CLOSE;
        end
      end
      M_CH_ESC: begin
        if (eof) begin
          push = 1'b1;
          push_cmd.op = OP_END;
          push_cmd.tok_type = TT_ERR;
          push_cmd.err = EC_EOF_CHAR;
          mode_nxt = M_IDLE;
        end else begin
          lit_nxt = esc_ch;
          mode_nxt = M_CH_CLOSE;
        end
      end
      M_CH_CLOSE: begin
        push = 1'b1;
        mode_nxt = M_IDLE;
        if (eof) begin
          push_cmd.op = OP_END;
          push_cmd.tok_type = TT_ERR;
          push_cmd.err = EC_EOF_CHAR;
        end else if (ch == 8'h27) begin
          push_cmd.op = OP_LIT;
          push_cmd.data = lit_r;
          push_cmd.tok_type = TT_NUM;
        end else begin
          push_cmd.op = OP_END;
          push_cmd.tok_type = TT_ERR;
          push_cmd.err = EC_BAD_CHAR;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
        if (!eof && !is_ws) begin
          if (is_key) begin
            push = 1'b1;
            push_cmd.op = OP_KEY;
          end else if (ch == 8'h22) begin
            mode_nxt = M_STR;
          end else if (ch == 8'h27) begin
            mode_nxt = M_CH_OPEN;
          end else begin
            mode_nxt = M_WORD;
            class_nxt = class_next(C_START, ch);
            push = 1'b1;
          end
        end
      end
    endcase
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      class_r <= C_START;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      class_r <= class_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lit_r <= lit_nxt;
    end
  end

endmodule

/* rtl/stl_fifo.sv */
module stl_fifo import stl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/stl_back.sv */
module stl_back import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_token_byte,
  output logic       out_byte_valid,
  output logic       out_token_end,
  output logic [2:0] out_token_type,
  output logic [2:0] out_error_code
);

  logic        valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        bv_r, bv_nxt;
  logic        end_r, end_nxt;
  logic [2:0]  type_r, type_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [1:0]  idx_r;
  logic [1:0]  last_idx;
  logic        load;

  // decimal text of a character literal
  logic        neg;
  logic [7:0]  mag;
  logic        hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [7:0]  dig [3];
  logic [7:0]  txt [4];
  logic [2:0]  lit_len;

  always_comb begin
    neg  = cmd.data[7];
    mag  = neg ? (~cmd.data + 8'd1) : cmd.data;
    hund = (mag >= 8'd100);
    rem  = hund ? 7'(mag - 8'd100) : mag[6:0];
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem - (7'(tens) * 7'd10));
    if (hund) begin
      dig[0] = 8'h31;
      dig[1] = 8'h30 + {4'b0, tens};
      dig[2] = 8'h30 + {4'b0, ones};
    end else if (tens != 4'd0) begin
      dig[0] = 8'h30 + {4'b0, tens};
      dig[1] = 8'h30 + {4'b0, ones};
      dig[2] = 8'h30;
    end else begin
      dig[0] = 8'h30 + {4'b0, ones};
      dig[1] = 8'h30;
      dig[2] = 8'h30;
    end
    lit_len = {2'b0, neg} + (hund ? 3'd3 : ((tens != 4'd0) ? 3'd2 : 3'd1));
    if (neg) begin
      txt[0] = 8'h2d;
      txt[1] = dig[0];
      txt[2] = dig[1];
      txt[3] = dig[2];
    end else begin
      txt[0] = dig[0];
      txt[1] = dig[1];
      txt[2] = dig[2];
      txt[3] = 8'h30;
    end
  end

  always_comb begin
    last_idx = 2'd0;
    byte_nxt = 8'h00;
    bv_nxt   = 1'b0;
    end_nxt  = 1'b0;
    type_nxt = TT_KEY;
    err_nxt  = EC_NONE;
    unique case (cmd.op)
      OP_BYTE: begin
        byte_nxt = cmd.data;
        bv_nxt   = 1'b1;
      end
      OP_END: begin
        end_nxt  = 1'b1;
        type_nxt = cmd.tok_type;
        err_nxt  = cmd.err;
      end
      OP_KEY: begin
        byte_nxt = cmd.data;
        bv_nxt   = (cmd.data != 8'h00);
        end_nxt  = 1'b1;
      end
      OP_WORD_KEY: begin
        last_idx = 2'd1;
        end_nxt  = 1'b1;
        if (idx_r == 2'd0) begin
          type_nxt = cmd.tok_type;
        end else begin
          byte_nxt = cmd.data;
          bv_nxt   = (cmd.data != 8'h00);
        end
      end
      OP_LIT: begin
        last_idx = 2'(lit_len - 3'd1);
        byte_nxt = txt[idx_r];
        bv_nxt   = 1'b1;
        end_nxt  = (idx_r == last_idx);
        type_nxt = end_nxt ? TT_NUM : TT_KEY;
      end
      default: begin
        end_nxt = 1'b0;
      end
    endcase
  end

  // refill the output register whenever it is empty or being drained
  assign load = cmd_valid && (!valid_r || out_ready);
  assign pop  = load && (idx_r == last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
      if (load) begin
        idx_r <= (idx_r == last_idx) ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      bv_r   <= bv_nxt;
      end_r  <= end_nxt;
      type_r <= type_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_token_byte = byte_r;
  assign out_byte_valid = bv_r;
  assign out_token_end  = end_r;
  assign out_token_type = type_r;
  assign out_error_code = err_r;

endmodule

/* rtl/source_token_lexer.sv */
// Commands enter the command queue as source bytes are accepted and are then
//   expanded into result beats in the output register.
// Throughput: one source byte per cycle in; one result beat per cycle out while
//   out_ready is high; a key-closed word yields two beats, a literal up to four.
// The input stalls only when the QUEUE_DEPTH-entry command queue is full.
// Reset (rst_n low, synchronous): lexer idle between tokens, queue and output empty.
module source_token_lexer import stl_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_token_byte,
  output logic       out_byte_valid,
  output logic       out_token_end,
  output logic [2:0] out_token_type,
  output logic [2:0] out_error_code
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic not_empty;
  cmd_t head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  stl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_kind      (in_kind),
    .in_char_byte (in_char_byte),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  stl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  stl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (not_empty),
    .cmd            (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_byte (out_token_byte),
    .out_byte_valid (out_byte_valid),
    .out_token_end  (out_token_end),
    .out_token_type (out_token_type),
    .out_error_code (out_error_code)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import stl_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int CHAR_TARGET  = 266;
  localparam logic [7:0] ESC_CHAR = 8'h1b;

  typedef enum logic [3:0] {
    LM_IDLE, LM_WORD, LM_STR, LM_STR_ESC, LM_STR_CUT, LM_STR_CUT_ESC,
    LM_CH_OPEN, LM_CH_ESC, LM_CH_CLOSE
  } lex_mode_t;

  typedef enum logic [2:0] {
    NC_START, NC_SIGN, NC_ZERO, NC_HEXPFX, NC_HEX, NC_OCT, NC_DEC, NC_DEAD
  } num_class_t;

  typedef struct {
    logic       kind;
    logic [7:0] ch;
    bit         drain;  // offer only once every pending token beat has arrived
  } src_char_t;

  typedef struct {
    logic [7:0] tbyte;
    logic       bvalid;
    logic       tend;
    logic [2:0] ttype;
    logic [2:0] ecode;
  } token_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = 1'b0;
  logic [7:0] in_char_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_token_byte;
  logic       out_byte_valid;
  logic       out_token_end;
  logic [2:0] out_token_type;
  logic [2:0] out_error_code;

  src_char_t   char_q[$];
  token_beat_t token_beats_q[$];

  lex_mode_t  lx_mode = LM_IDLE;
  num_class_t lx_class = NC_START;
  logic [7:0] lx_lit = 8'h00;

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  in_beats = 0;
  bit  char_taken = 1'b0;
  int  src_gap = 0;
  int  src_quiet = 0;
  int  rcv_gap = 0;
  int  rcv_quiet = 0;
  int  rcv_hold = 0;
  bit  long_hold_done = 1'b0;

  source_token_lexer i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_ws(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic bit is_key(logic [7:0] b);
    return b == 8'h00 || b == "!" || b == "@" || b == "#" || b == "(" ||
           b == ")" || b == "[" || b == "]";
  endfunction

  function automatic bit is_hex(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic num_class_t class_next(num_class_t s, logic [7:0] b);
    bit dig;
    bit oct;
    dig = b >= "0" && b <= "9";
    oct = b >= "0" && b <= "7";
    if (s == NC_START && (b == "+" || b == "-")) return NC_SIGN;
    case (s)
      NC_START, NC_SIGN: begin
        if (b == "0") return NC_ZERO;
        if (dig) return NC_DEC;
        return NC_DEAD;
      end
      NC_ZERO: begin
        if (b == "x" || b == "X") return NC_HEXPFX;
        if (oct) return NC_OCT;
        return NC_DEAD;
      end
      NC_HEXPFX, NC_HEX: return is_hex(b) ? NC_HEX : NC_DEAD;
      NC_OCT: return oct ? NC_OCT : NC_DEAD;
      NC_DEC: return dig ? NC_DEC : NC_DEAD;
      default: return NC_DEAD;
    endcase
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] b, bit in_lit);
    if (b == "n") return 8'h0a;
    if (b == "t") return 8'h09;
    if (b == "[") return ESC_CHAR;
    if (in_lit && b == "b") return 8'h08;
    return b;
  endfunction

  function automatic void emit_beat(logic [7:0] b, bit v, bit e, logic [2:0] t,
                                    logic [2:0] ec);
    token_beat_t beat;
    beat.tbyte  = v ? b : 8'h00;
    beat.bvalid = v;
    beat.tend   = e;
    beat.ttype  = e ? t : TT_KEY;
    beat.ecode  = (e && t == TT_ERR) ? ec : EC_NONE;
    token_beats_q.push_back(beat);
  endfunction

  function automatic void emit_error(logic [2:0] ec);
    emit_beat(8'h00, 1'b0, 1'b1, TT_ERR, ec);
    lx_mode = LM_IDLE;
  endfunction

  function automatic void emit_key(logic [7:0] b);
    emit_beat(b, b != 8'h00, 1'b1, TT_KEY, EC_NONE);
  endfunction

  // a NUL ends the text; the rest of the string is swallowed
  function automatic void string_push(logic [7:0] b, bit cut);
    if (cut || b == 8'h00) begin
      lx_mode = LM_STR_CUT;
    end else begin
      lx_mode = LM_STR;
      emit_beat(b, 1'b1, 1'b0, TT_KEY, EC_NONE);
    end
  endfunction

  function automatic void lex_char(logic eof, logic [7:0] ch);
    string txt;
    case (lx_mode)
      LM_WORD: begin
        if (eof || is_ws(ch) || is_key(ch)) begin
          emit_beat(8'h00, 1'b0, 1'b1,
                    (lx_class inside {NC_ZERO, NC_HEX, NC_OCT, NC_DEC}) ? TT_NUM : TT_TAG,
                    EC_NONE);
          lx_mode = LM_IDLE;
          if (!eof && is_key(ch)) emit_key(ch);
        end else begin
          lx_class = class_next(lx_class, ch);
          emit_beat(ch, 1'b1, 1'b0, TT_KEY, EC_NONE);
        end
      end
      LM_STR, LM_STR_CUT: begin
        if (eof) emit_error(EC_OPEN_STR);
        else if (ch == "\\") lx_mode = (lx_mode == LM_STR) ? LM_STR_ESC : LM_STR_CUT_ESC;
        else if (ch == "\"") begin
          emit_beat(8'h00, 1'b0, 1'b1, TT_STR, EC_NONE);
          lx_mode = LM_IDLE;
        end else string_push(ch, lx_mode == LM_STR_CUT);
      end
      LM_STR_ESC, LM_STR_CUT_ESC: begin
        if (eof) emit_error(EC_OPEN_ESC);
        else string_push(esc_map(ch, 1'b0), lx_mode == LM_STR_CUT_ESC);
      end
      LM_CH_OPEN: begin
        if (eof) emit_error(EC_EOF_CHAR);
        else if (ch == "\\") lx_mode = LM_CH_ESC;
        else begin
          lx_lit = ch;
          lx_mode = LM_CH_CLOSE;
        end
      end
      LM_CH_ESC: begin
        if (eof) emit_error(EC_EOF_CHAR);
        else begin
          lx_lit = esc_map(ch, 1'b1);
          lx_mode = LM_CH_CLOSE;
        end
      end
      LM_CH_CLOSE: begin
        if (eof) emit_error(EC_EOF_CHAR);
        else if (ch == "'") begin
          txt = $sformatf("%0d", $signed(lx_lit));
          for (int i = 0; i < txt.len(); i++)
            emit_beat(txt[i], 1'b1, i == txt.len() - 1, TT_NUM, EC_NONE);
          lx_mode = LM_IDLE;
        end else emit_error(EC_BAD_CHAR);
      end
      default: begin
        lx_mode = LM_IDLE;
        if (!(eof || is_ws(ch))) begin
          if (is_key(ch)) emit_key(ch);
          else if (ch == "\"") lx_mode = LM_STR;
          else if (ch == "'") lx_mode = LM_CH_OPEN;
          else begin
            lx_mode = LM_WORD;
            lx_class = class_next(NC_START, ch);
            emit_beat(ch, 1'b1, 1'b0, TT_KEY, EC_NONE);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_src(logic kind, logic [7:0] ch);
    src_char_t c;
    c.kind  = kind;
    c.ch    = ch;
    c.drain = 1'b0;
    char_q.push_back(c);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_src(1'b0, s[i]);
  endfunction

  function automatic void push_eof();
    push_src(1'b1, 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] rand_ws();
    int idx;
    idx = $urandom_range(0, 5);
    return (idx == 0) ? 8'h20 : 8'(8 + idx);
  endfunction

  function automatic logic [7:0] rand_key();
    string keyset;
    int    idx;
    keyset = "!@#()[]";
    idx = $urandom_range(0, 7);
    return (idx == 7) ? 8'h00 : keyset[idx];
  endfunction

  function automatic void push_delim();
    case ($urandom_range(0, 4))
      0, 1: push_src(1'b0, rand_ws());
      2, 3: push_src(1'b0, rand_key());
      default: push_eof();
    endcase
  endfunction

  function automatic logic [7:0] rand_esc();
    string escset;
    escset = "nt[b\"\\'0";
    return escset[$urandom_range(0, 7)];
  endfunction

  task automatic add_random_tokens(int target);
    int         len;
    logic [7:0] b;
    string      hexset;
    hexset = "0123456789abcdefABCDEF";
    while (char_q.size() < target) begin
      case ($urandom_range(0, 19))
        0, 1: push_src(1'b0, rand_ws());
        2, 3: push_src(1'b0, rand_key());
        4, 5, 6: begin
          if ($urandom_range(0, 2) == 0) push_src(1'b0, $urandom_range(0, 1) ? "+" : "-");
          len = $urandom_range(0, 3);
          case ($urandom_range(0, 2))
            0: begin
              push_src(1'b0, "0");
              push_src(1'b0, $urandom_range(0, 1) ? "x" : "X");
              repeat (len + 1) push_src(1'b0, hexset[$urandom_range(0, 21)]);
            end
            1: begin
              push_src(1'b0, "0");
              repeat (len) push_src(1'b0, 8'("0" + $urandom_range(0, 7)));
            end
            default: begin
              push_src(1'b0, 8'("1" + $urandom_range(0, 8)));
              repeat (len) push_src(1'b0, 8'("0" + $urandom_range(0, 9)));
            end
          endcase
          push_delim();
        end
        7, 8: begin
          do b = 8'($urandom_range(0, 255));
          while (is_ws(b) || is_key(b) || b == "\"" || b == "'");
          push_src(1'b0, b);
          repeat ($urandom_range(0, 4)) begin
            do b = 8'($urandom_range(0, 255)); while (is_ws(b) || is_key(b));
            push_src(1'b0, b);
          end
          push_delim();
        end
        9, 10, 11: begin
          push_src(1'b0, "\"");
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 9))
              0: begin
                push_src(1'b0, "\\");
                push_src(1'b0, 8'($urandom_range(0, 255)));
              end
              1, 2: begin
                push_src(1'b0, "\\");
                push_src(1'b0, rand_esc());
              end
              3: begin
                if ($urandom_range(0, 1)) push_src(1'b0, "\\");
                push_src(1'b0, 8'h00);
              end
              default: begin
                do b = 8'($urandom_range(1, 255)); while (b == "\"" || b == "\\");
                push_src(1'b0, b);
              end
            endcase
          end
          push_src(1'b0, "\"");
        end
        14: begin
          push_src(1'b0, "\"");
          if ($urandom_range(0, 1)) push_src(1'b0, "a");
          if ($urandom_range(0, 1)) push_src(1'b0, "\\");
          push_eof();
        end
        15: begin
          push_src(1'b0, "'");
          case ($urandom_range(0, 3))
            0: push_eof();
            1: begin
              push_src(1'b0, "\\");
              push_eof();
            end
            2: begin
              push_src(1'b0, 8'($urandom_range(0, 255)));
              push_eof();
            end
            default: begin
              push_src(1'b0, "x");
              do b = 8'($urandom_range(0, 255)); while (b == "'");
              push_src(1'b0, b);
            end
          endcase
        end
        16: push_eof();
        17: push_src(1'b0, 8'($urandom_range(0, 255)));
        18: begin
          case ($urandom_range(0, 3))
            0: push_text("0x");
            1: push_text("09");
            2: push_text("+");
            default: push_text("12a");
          endcase
          push_delim();
        end
        default: begin
          push_src(1'b0, "'");
          if ($urandom_range(0, 2) == 0) begin
            push_src(1'b0, "\\");
            push_src(1'b0, $urandom_range(0, 1) ? rand_esc() : 8'($urandom_range(0, 255)));
          end else begin
            do b = 8'($urandom_range(0, 255)); while (b == "\\");
            push_src(1'b0, b);
          end
          push_src(1'b0, "'");
        end
      endcase
    end
  endtask

  function automatic bit calm();
    return char_q.size() < 40;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !char_taken)) begin
      char_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (char_q.size() == 0 || (char_q[0].drain && token_beats_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (!calm() && !(in_beats >= 55 && in_beats < 90) && src_quiet == 0 &&
                   $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 13);
        src_quiet = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 80) : 0;
        in_valid <= 1'b0;
      end else begin
        if (src_quiet > 0) src_quiet--;
        char_q[0].drain = 1'b0;
        in_valid     <= 1'b1;
        in_kind      <= char_q[0].kind;
        in_char_byte <= char_q[0].ch;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      lex_char(in_kind, in_char_byte);
      void'(char_q.pop_front());
      in_beats++;
      char_taken = 1'b1;
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (in_beats >= 60 && !long_hold_done) begin
      // hold off long enough for the block to back up into its input
      long_hold_done = 1'b1;
      rcv_hold = 70;
      out_ready <= 1'b0;
    end else if (rcv_hold > 0) begin
      rcv_hold--;
      out_ready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_ready <= 1'b0;
    end else if (!calm() && rcv_quiet == 0 && $urandom_range(0, 7) == 0) begin
      rcv_gap = $urandom_range(0, 13);
      rcv_quiet = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 80) : 0;
      out_ready <= 1'b0;
    end else begin
      if (rcv_quiet > 0) rcv_quiet--;
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    token_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (token_beats_q.size() == 0) begin
        $display({"%0t: unexpected beat, expected none, ",
                  "actual byte %0d bv %0d end %0d type %0d err %0d"},
                 $time, out_token_byte, out_byte_valid, out_token_end, out_token_type,
                 out_error_code);
        err_cnt++;
      end else begin
        want = token_beats_q.pop_front();
        check_field("token_byte", want.tbyte, out_token_byte);
        check_field("byte_valid", want.bvalid, out_byte_valid);
        check_field("token_end", want.tend, out_token_end);
        check_field("token_type", want.ttype, out_token_type);
        check_field("error_code", want.ecode, out_error_code);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // key characters, NUL among them; a hex word closed by a key character
    push_src(1'b0, 8'h00);
    push_text("0x1F[");
    // high byte makes a tag, tab closes it
    push_src(1'b0, 8'hff);
    push_src(1'b0, 8'h09);
    // escape to ESC, then a raw NUL cuts the text
    push_text("\"\\[");
    push_src(1'b0, 8'h00);
    push_text("z\"");
    // negative character literal
    push_text("'");
    push_src(1'b0, 8'h80);
    push_text("'");
    // escaped backspace literal with a bad closing byte
    push_text("'\\bx");
    // end of input after a string backslash, in a literal, in a string, at idle
    push_text("\"\\");
    push_src(1'b1, 8'h00);
    push_text("'");
    push_src(1'b1, 8'hff);
    push_text("\"");
    push_src(1'b1, 8'h55);
    push_src(1'b1, 8'haa);

    add_random_tokens(CHAR_TARGET / 2);
    char_q[char_q.size() - 1].drain = 1'b1;
    add_random_tokens(CHAR_TARGET);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0) @(posedge clk);
    while (token_beats_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
    $display("%0t: timeout, %0d source beats still pending, %0d token beats outstanding",
             $time, char_q.size(), token_beats_q.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
